[rtl/core/rma_pkg.sv]
package rma_pkg;

    localparam int FRAC      = 14;
    localparam int MW        = FRAC + 2;        // matrix entry width
    localparam int EW        = MW + 1;          // rotation entry width (holds -s)
    localparam int PW        = MW + EW + 2;     // sum of three products
    localparam int VW        = 17;              // vector result width
    localparam int VSW       = MW + 16 + 2;     // sum of three vector products
    localparam int XW        = 34;              // CORDIC x, y (Q30)
    localparam int ZW        = 22;              // CORDIC angle (Q16)
    localparam int STEPS     = 16;
    localparam int SCW       = XW - (30 - FRAC);

    localparam logic signed [XW-1:0] GAIN_Q30   = 34'sd652032874;
    localparam logic signed [ZW-1:0] PI_Q16     = 22'sd205887;
    localparam logic signed [ZW-1:0] HALF_PI_Q16 = 22'sd102944;
    localparam logic signed [ZW-1:0] TWO_PI_Q16 = 22'sd411775;

    localparam logic [1:0] ACT_IDENT  = 2'd0;
    localparam logic [1:0] ACT_ROTATE = 2'd1;
    localparam logic [1:0] ACT_VECTOR = 2'd2;
    localparam logic [1:0] ACT_NOP    = 2'd3;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_ANGLE = 9'b000000010,
        ST_WRAP  = 9'b000000100,
        ST_ROT   = 9'b000001000,
        ST_SC    = 9'b000010000,
        ST_MUL   = 9'b000100000,
        ST_VEC   = 9'b001000000,
        ST_RES   = 9'b010000000,
        ST_NEXT  = 9'b100000000
    } state_t;

    typedef struct packed {
        logic       ident;
        logic       latch;
        logic       ang_load;
        logic       wrap;
        logic       cordic;
        logic       sc_load;
        logic       mul;
        logic       vec;
        logic       out_load;
        logic [1:0] axis;
        logic [3:0] step;
        logic [1:0] col;
    } cmd_t;

    typedef struct packed {
        logic z_reduced;
    } status_t;

    function automatic logic signed [ZW-1:0] atan_q16(input logic [3:0] i);
        case (i)
            4'd0:    atan_q16 = 22'sd51472;
            4'd1:    atan_q16 = 22'sd30386;
            4'd2:    atan_q16 = 22'sd16055;
            4'd3:    atan_q16 = 22'sd8150;
            4'd4:    atan_q16 = 22'sd4091;
            4'd5:    atan_q16 = 22'sd2047;
            4'd6:    atan_q16 = 22'sd1024;
            4'd7:    atan_q16 = 22'sd512;
            4'd8:    atan_q16 = 22'sd256;
            4'd9:    atan_q16 = 22'sd128;
            4'd10:   atan_q16 = 22'sd64;
            4'd11:   atan_q16 = 22'sd32;
            4'd12:   atan_q16 = 22'sd16;
            4'd13:   atan_q16 = 22'sd8;
            4'd14:   atan_q16 = 22'sd4;
            default: atan_q16 = 22'sd2;
        endcase
    endfunction

    // Saturate a wide value to a matrix entry.
    function automatic logic signed [MW-1:0] sat_m(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] hi;
        logic signed [PW-1:0] lo;
        hi = PW'((64'sd1 <<< (MW - 1)) - 64'sd1);
        lo = -hi - PW'(1);
        if (v > hi)      sat_m = hi[MW-1:0];
        else if (v < lo) sat_m = lo[MW-1:0];
        else             sat_m = v[MW-1:0];
    endfunction

    // Element idx (column-major) of the rotation matrix about axis.
    function automatic logic signed [EW-1:0] rot_elem(input logic [1:0] axis,
                                                     input logic [3:0] idx,
                                                     input logic signed [MW-1:0] s,
                                                     input logic signed [MW-1:0] c);
        logic signed [EW-1:0] one;
        logic signed [EW-1:0] se;
        logic signed [EW-1:0] ce;
        one = EW'(1) <<< FRAC;
        se  = EW'(s);
        ce  = EW'(c);
        rot_elem = '0;
        if (idx == 4'd0 || idx == 4'd4 || idx == 4'd8) rot_elem = one;
        case (axis)
            AXIS_X: begin
                case (idx)
                    4'd4, 4'd8: rot_elem = ce;
                    4'd5:       rot_elem = se;
                    4'd7:       rot_elem = -se;
                    default:    ;
                endcase
            end
            AXIS_Y: begin
                case (idx)
                    4'd0, 4'd8: rot_elem = ce;
                    4'd2:       rot_elem = -se;
                    4'd6:       rot_elem = se;
                    default:    ;
                endcase
            end
            default: begin
                case (idx)
                    4'd0, 4'd4: rot_elem = ce;
                    4'd1:       rot_elem = se;
                    4'd3:       rot_elem = -se;
                    default:    ;
                endcase
            end
        endcase
    endfunction

endpackage

[rtl/core/rotation_matrix_accumulator.sv]
// Channel  | Ports                                   | Carries
// ---------+-----------------------------------------+-------------------------------
// request  | s_valid s_ready s_action s_angle_* s_vec_* | action, zyx angles, vector
// result   | m_valid m_ready m_out_x/y/z m_clipped     | rotated vector, clip flag
//
// An identity load completes in the accept cycle; a transform runs its three
// vector rows before the result register loads. A rotation takes the accept
// cycle and, per axis, one angle load, wrap cycles until the angle is reduced,
// 16 CORDIC steps, one sine/cosine round, nine matrix entries through the
// three-multiplier matrix dot product and one axis step.
// aresetn is synchronous, active low, and loads the identity matrix.
// A result waiting on m_ready holds the block only when the next transform
// is ready to load its result.
module rotation_matrix_accumulator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_action,
    input  logic signed [15:0] s_angle_x,
    input  logic signed [15:0] s_angle_y,
    input  logic signed [15:0] s_angle_z,
    input  logic signed [15:0] s_vec_x,
    input  logic signed [15:0] s_vec_y,
    input  logic signed [15:0] s_vec_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [16:0] m_out_x,
    output logic signed [16:0] m_out_y,
    output logic signed [16:0] m_out_z,
    output logic               m_clipped
);

    rma_pkg::cmd_t    cmd;
    rma_pkg::status_t st;

    // sequence each request: per rotation axis, cordic then the matrix product; a transform runs the vector product
    rma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // hold the matrix, the CORDIC registers and the result register
    rma_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_angle_x (s_angle_x),
        .s_angle_y (s_angle_y),
        .s_angle_z (s_angle_z),
        .s_vec_x   (s_vec_x),
        .s_vec_y   (s_vec_y),
        .s_vec_z   (s_vec_z),
        .m_out_x   (m_out_x),
        .m_out_y   (m_out_y),
        .m_out_z   (m_out_z),
        .m_clipped (m_clipped)
    );

endmodule

[rtl/core/rma_ctrl.sv]
module rma_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_action,
    output logic             m_valid,
    input  logic             m_ready,
    input  rma_pkg::status_t st,
    output rma_pkg::cmd_t    cmd
);

    rma_pkg::state_t state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic [3:0] step_reg, step_next;
    logic [1:0] col_reg, col_next;
    logic [1:0] row_reg, row_next;
    logic       mv_reg, mv_next;
    logic       accept;

    assign s_ready = (state_reg == rma_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = mv_reg;

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        step_next  = step_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = '0;
        cmd.axis   = axis_reg;
        cmd.step   = step_reg;
        cmd.col    = col_reg;
        case (state_reg)
            rma_pkg::ST_IDLE: begin
                if (accept) begin
                    cmd.latch = 1'b1;
                    case (s_action)
                        rma_pkg::ACT_IDENT:  cmd.ident = 1'b1;
                        rma_pkg::ACT_ROTATE: begin
                            axis_next  = rma_pkg::AXIS_Z;
                            state_next = rma_pkg::ST_ANGLE;
                        end
                        rma_pkg::ACT_VECTOR: begin
                            row_next   = 2'd0;
                            state_next = rma_pkg::ST_VEC;
                        end
                        default: ;
                    endcase
                end
            end
            rma_pkg::ST_ANGLE: begin
                cmd.ang_load = 1'b1;
                state_next   = rma_pkg::ST_WRAP;
            end
            rma_pkg::ST_WRAP: begin
                cmd.wrap = 1'b1;
                if (st.z_reduced) begin
                    step_next  = '0;
                    state_next = rma_pkg::ST_ROT;
                end
            end
            rma_pkg::ST_ROT: begin
                cmd.cordic = 1'b1;
                step_next  = step_reg + 4'd1;
                if (step_reg == 4'(rma_pkg::STEPS - 1)) state_next = rma_pkg::ST_SC;
            end
            rma_pkg::ST_SC: begin
                cmd.sc_load = 1'b1;
                col_next    = '0;
                row_next    = '0;
                state_next  = rma_pkg::ST_MUL;
            end
            rma_pkg::ST_MUL: begin
                cmd.mul  = 1'b1;
                col_next = (col_reg == 2'd2) ? 2'd0 : col_reg + 2'd1;
                if (col_reg == 2'd2) begin
                    row_next = row_reg + 2'd1;
                    if (row_reg == 2'd2) state_next = rma_pkg::ST_NEXT;
                end
            end
            rma_pkg::ST_NEXT: begin
                if (axis_reg == rma_pkg::AXIS_X) begin
                    state_next = rma_pkg::ST_IDLE;
                end else begin
                    axis_next  = axis_reg - 2'd1;
                    state_next = rma_pkg::ST_ANGLE;
                end
            end
            rma_pkg::ST_VEC: begin
                cmd.vec  = 1'b1;
                row_next = row_reg + 2'd1;
                if (row_reg == 2'd2) state_next = rma_pkg::ST_RES;
            end
            rma_pkg::ST_RES: begin
                if (!mv_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    mv_next      = 1'b1;
                    state_next   = rma_pkg::ST_IDLE;
                end
            end
            default: state_next = rma_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rma_pkg::ST_IDLE;
            axis_reg  <= '0;
            step_reg  <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            step_reg  <= step_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            mv_reg    <= mv_next;
        end
    end

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!mv_reg || m_ready))
        else $error("result loaded over an unread result");
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg != 2'd3)
        else $error("column counter out of range");
    a_mul_from_sc: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == rma_pkg::ST_MUL) |-> $past(state_reg == rma_pkg::ST_SC))
        else $error("product started without sine and cosine");
    a_valid_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mv_reg) |-> $past(state_reg == rma_pkg::ST_RES))
        else $error("result raised outside the result state");

endmodule

[rtl/core/rma_datapath.sv]
module rma_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rma_pkg::cmd_t         cmd,
    output rma_pkg::status_t      st,
    input  logic signed [15:0]    s_angle_x,
    input  logic signed [15:0]    s_angle_y,
    input  logic signed [15:0]    s_angle_z,
    input  logic signed [15:0]    s_vec_x,
    input  logic signed [15:0]    s_vec_y,
    input  logic signed [15:0]    s_vec_z,
    output logic signed [16:0]    m_out_x,
    output logic signed [16:0]    m_out_y,
    output logic signed [16:0]    m_out_z,
    output logic                  m_clipped
);

    localparam int MW = rma_pkg::MW;
    localparam int EW = rma_pkg::EW;
    localparam int PW = rma_pkg::PW;
    localparam int XW = rma_pkg::XW;
    localparam int ZW = rma_pkg::ZW;
    localparam int VSW = rma_pkg::VSW;

    // orientation held as three rows; row 0 always feeds the multipliers
    logic signed [MW-1:0] row_reg [3][3];
    logic signed [15:0]   ang_reg [3];
    logic signed [15:0]   v_reg [3];
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic                 neg_reg;
    logic signed [MW-1:0] s_reg, c_reg;
    logic signed [MW-1:0] tmp_reg [2];
    logic signed [16:0]   res_reg [3];
    logic                 clip_reg;

    logic signed [ZW-1:0] ang_ext;
    logic signed [XW-1:0] dx, dy;
    logic signed [rma_pkg::SCW-1:0] s_rnd, c_rnd;
    logic signed [PW-1:0] s_w, c_w;
    logic signed [EW-1:0] me [3];
    logic signed [PW-1:0] macc;
    logic signed [MW-1:0] mnew;
    logic signed [VSW-1:0] vacc, vsh;
    logic signed [16:0]   vnew;
    logic                 vhit;

    always_comb begin
        case (cmd.axis)
            rma_pkg::AXIS_X: ang_ext = {{2{ang_reg[0][15]}}, ang_reg[0], 4'b0};
            rma_pkg::AXIS_Y: ang_ext = {{2{ang_reg[1][15]}}, ang_reg[1], 4'b0};
            default:         ang_ext = {{2{ang_reg[2][15]}}, ang_reg[2], 4'b0};
        endcase
    end

    assign st.z_reduced = (z_reg <= rma_pkg::HALF_PI_Q16) && (z_reg >= -rma_pkg::HALF_PI_Q16);

    assign dx = y_reg >>> cmd.step;
    assign dy = x_reg >>> cmd.step;

    // round half up from Q30 to Q2.F, then sign and saturate
    assign s_rnd = rma_pkg::SCW'((y_reg + (XW'(1) <<< (29 - rma_pkg::FRAC))) >>> (30 - rma_pkg::FRAC));
    assign c_rnd = rma_pkg::SCW'((x_reg + (XW'(1) <<< (29 - rma_pkg::FRAC))) >>> (30 - rma_pkg::FRAC));
    assign s_w = neg_reg ? -PW'(s_rnd) : PW'(s_rnd);
    assign c_w = neg_reg ? -PW'(c_rnd) : PW'(c_rnd);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            me[k] = rma_pkg::rot_elem(cmd.axis, 4'(k) + 4'(3) * {2'b0, cmd.col}, s_reg, c_reg);
        end
    end

    assign macc = PW'(row_reg[0][0] * me[0]) + PW'(row_reg[0][1] * me[1])
                + PW'(row_reg[0][2] * me[2]) + (PW'(1) <<< (rma_pkg::FRAC - 1));
    assign mnew = rma_pkg::sat_m(macc >>> rma_pkg::FRAC);

    assign vacc = VSW'(row_reg[0][0] * v_reg[0]) + VSW'(row_reg[0][1] * v_reg[1])
                + VSW'(row_reg[0][2] * v_reg[2]) + (VSW'(1) <<< (rma_pkg::FRAC - 1));
    assign vsh  = vacc >>> rma_pkg::FRAC;
    always_comb begin
        vhit = 1'b1;
        if (vsh > VSW'(65535))       vnew = 17'sd65535;
        else if (vsh < -VSW'(65536)) vnew = -17'sd65536;
        else begin
            vnew = vsh[16:0];
            vhit = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    row_reg[r][k] <= (r == k) ? (MW'(1) <<< rma_pkg::FRAC) : '0;
                end
            end
        end else if (cmd.ident) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    row_reg[r][k] <= (r == k) ? (MW'(1) <<< rma_pkg::FRAC) : '0;
                end
            end
        end else if (cmd.mul && cmd.col == 2'd2) begin
            row_reg[0] <= row_reg[1];
            row_reg[1] <= row_reg[2];
            row_reg[2] <= '{tmp_reg[0], tmp_reg[1], mnew};
        end else if (cmd.vec) begin
            row_reg[0] <= row_reg[1];
            row_reg[1] <= row_reg[2];
            row_reg[2] <= row_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            ang_reg  <= '{s_angle_x, s_angle_y, s_angle_z};
            v_reg    <= '{s_vec_x, s_vec_y, s_vec_z};
            clip_reg <= 1'b0;
        end
        if (cmd.ang_load) begin
            z_reg   <= ang_ext;
            x_reg   <= rma_pkg::GAIN_Q30;
            y_reg   <= '0;
            neg_reg <= 1'b0;
        end else if (cmd.wrap) begin
            if (z_reg > rma_pkg::PI_Q16) begin
                z_reg <= z_reg - rma_pkg::TWO_PI_Q16;
            end else if (z_reg < -rma_pkg::PI_Q16) begin
                z_reg <= z_reg + rma_pkg::TWO_PI_Q16;
            end else if (z_reg > rma_pkg::HALF_PI_Q16) begin
                z_reg   <= z_reg - rma_pkg::PI_Q16;
                neg_reg <= 1'b1;
            end else if (z_reg < -rma_pkg::HALF_PI_Q16) begin
                z_reg   <= z_reg + rma_pkg::PI_Q16;
                neg_reg <= 1'b1;
            end
        end else if (cmd.cordic) begin
            if (z_reg >= 0) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - rma_pkg::atan_q16(cmd.step);
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + rma_pkg::atan_q16(cmd.step);
            end
        end
        if (cmd.sc_load) begin
            s_reg <= rma_pkg::sat_m(s_w);
            c_reg <= rma_pkg::sat_m(c_w);
        end
        if (cmd.mul && cmd.col != 2'd2) begin
            tmp_reg[cmd.col[0]] <= mnew;
        end
        if (cmd.vec) begin
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
            res_reg[2] <= vnew;
            clip_reg   <= clip_reg | vhit;
        end
        if (cmd.out_load) begin
            m_out_x   <= res_reg[0];
            m_out_y   <= res_reg[1];
            m_out_z   <= res_reg[2];
            m_clipped <= clip_reg;
        end
    end

endmodule
